// ===== design/rwsd_pkg.sv =====
`default_nettype none

package rwsd_pkg;

    localparam int unsigned TS_W     = 32;
    localparam int unsigned TOT_W    = 24;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TS_W-1:0] MS_PER_S = 32'd1000;

    localparam logic [CFG_W-1:0] WINDOW_S_RST = 16'd600;
    localparam logic [CFG_W-1:0] RAIN_THR_RST = 16'd50;
    localparam logic [CFG_W-1:0] DRY_S_RST    = 16'd1800;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_S = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIN_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_S    = 2'd2;

    typedef enum logic [1:0] {
        RS_UNKNOWN = 2'd0,
        RS_RAINING = 2'd1,
        RS_DRY     = 2'd2
    } t_rain_state;

    typedef struct packed {
        logic [TS_W-1:0]  ts_ms;
        logic [TOT_W-1:0] total;
    } t_sample;

    typedef struct packed {
        logic [TS_W-1:0]  win_ms;
        logic [TS_W-1:0]  dry_ms;
        logic [CFG_W-1:0] rain_thr;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/rwsd_cfg.sv =====
`default_nettype none

module rwsd_cfg
    import rwsd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                      o_cfg
);

    localparam logic [TS_W-1:0] WIN_MS_RST = TS_W'(WINDOW_S_RST) * MS_PER_S;
    localparam logic [TS_W-1:0] DRY_MS_RST = TS_W'(DRY_S_RST) * MS_PER_S;

    t_cfg            r_cfg;
    logic [TS_W-1:0] n_ms;

    // seconds to milliseconds, folded in at write time
    assign n_ms = TS_W'(i_cfg_wdata) * MS_PER_S;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_ms   <= WIN_MS_RST;
            r_cfg.dry_ms   <= DRY_MS_RST;
            r_cfg.rain_thr <= RAIN_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_S: r_cfg.win_ms   <= n_ms;
                CFG_RAIN_THR: r_cfg.rain_thr <= i_cfg_wdata;
                CFG_DRY_S:    r_cfg.dry_ms   <= n_ms;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/rwsd_ring.sv =====
`default_nettype none

module rwsd_ring
    import rwsd_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
)(
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_sample       i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_sample            o_rdata
);

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/rwsd_ctrl.sv =====
`default_nettype none

module rwsd_ctrl
    import rwsd_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6,
    parameter int unsigned CW    = 7
)(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [TS_W-1:0]   i_now_ms,
    input  wire logic              i_read_ok,
    input  wire logic [TOT_W-1:0]  i_total_hundredths_mm,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_rain_state,
    output logic                   o_is_raining,
    output logic                   o_ready_res,
    output logic [TOT_W-1:0]       o_window_delta,
    output logic [TOT_W-1:0]       o_latest_total,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output t_sample                o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  wire t_sample           i_mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP,
        S_RD,
        S_CHK,
        S_UPD
    } t_st;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_S  = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [CW-1:0] TWO_C    = CW'(2);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + AW'(1);
    endfunction

    t_st                r_st, n_st;
    logic [TS_W-1:0]    r_now, n_now;
    logic               r_ok, n_ok;
    logic [TOT_W-1:0]   r_tot, n_tot;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    t_rain_state        r_cur, n_cur;
    logic               r_ready, n_ready;
    logic [TOT_W-1:0]   r_last_total, n_last_total;
    logic [TOT_W-1:0]   r_win_inc, n_win_inc;
    logic [TS_W-1:0]    r_last_rain, n_last_rain;
    logic               r_age_eq, n_age_eq;
    logic [TOT_W-1:0]   r_old_tot, n_old_tot;
    logic               r_out_valid, n_out_valid;
    t_rain_state        r_o_state, n_o_state;
    logic               r_o_ready, n_o_ready;
    logic [TOT_W-1:0]   r_o_delta, n_o_delta;
    logic [TOT_W-1:0]   r_o_total, n_o_total;

    logic               wipe;
    logic [AW-1:0]      h1, h2;
    logic [CW-1:0]      c1, c2;
    logic [AW:0]        wsum;
    logic [TS_W-1:0]    age;
    logic [TOT_W-1:0]   inc;

    always_comb begin
        wipe = (r_count != '0) && (r_tot < r_last_total);
        h1   = wipe ? '0 : r_head;
        c1   = wipe ? '0 : r_count;
        h2   = (c1 == DEPTH_C) ? idx_inc(h1) : h1;
        c2   = (c1 == DEPTH_C) ? c1 - CW'(1) : c1;
        wsum = (AW+1)'(h2) + (AW+1)'(c2);
        if (wsum >= DEPTH_S) begin
            wsum = wsum - DEPTH_S;
        end
        age = r_now - i_mem_rdata.ts_ms;
        inc = ((r_count >= TWO_C) && (r_tot >= r_old_tot)) ? r_tot - r_old_tot : '0;
    end

    assign o_mem_we          = (r_st == S_APP);
    assign o_mem_waddr       = wsum[AW-1:0];
    assign o_mem_wdata.ts_ms = r_now;
    assign o_mem_wdata.total = r_tot;
    assign o_mem_raddr       = (r_st == S_CHK) ? idx_inc(r_head) : r_head;

    always_comb begin
        n_st         = r_st;
        n_now        = r_now;
        n_ok         = r_ok;
        n_tot        = r_tot;
        n_head       = r_head;
        n_count      = r_count;
        n_cur        = r_cur;
        n_ready      = r_ready;
        n_last_total = r_last_total;
        n_win_inc    = r_win_inc;
        n_last_rain  = r_last_rain;
        n_age_eq     = r_age_eq;
        n_old_tot    = r_old_tot;
        n_out_valid  = r_out_valid && i_out_stall;
        n_o_state    = r_o_state;
        n_o_ready    = r_o_ready;
        n_o_delta    = r_o_delta;
        n_o_total    = r_o_total;

        unique case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_now = i_now_ms;
                    n_ok  = i_read_ok;
                    n_tot = i_total_hundredths_mm;
                    n_st  = i_read_ok ? S_APP : S_UPD;
                end
            end
            S_APP: begin
                if (wipe) begin
                    n_cur       = RS_UNKNOWN;
                    n_last_rain = '0;
                end
                n_head       = h2;
                n_count      = c2 + CW'(1);
                n_ready      = 1'b1;
                n_last_total = r_tot;
                n_st         = S_RD;
            end
            S_RD: begin
                n_st = S_CHK;
            end
            S_CHK: begin
                // drop stale entries; the newest one is never stale
                if (age > i_cfg.win_ms) begin
                    n_head  = idx_inc(r_head);
                    n_count = r_count - CW'(1);
                end else begin
                    n_age_eq  = (age == i_cfg.win_ms);
                    n_old_tot = i_mem_rdata.total;
                    n_st      = S_UPD;
                end
            end
            S_UPD: begin
                if (!(r_out_valid && i_out_stall)) begin
                    if (!r_ok) begin
                        n_cur = RS_UNKNOWN;
                    end else begin
                        n_win_inc = inc;
                        if (inc >= TOT_W'(i_cfg.rain_thr)) begin
                            n_cur       = RS_RAINING;
                            n_last_rain = r_now;
                        end else if (r_cur == RS_RAINING) begin
                            if ((r_last_rain != '0) &&
                                ((r_now - r_last_rain) >= i_cfg.dry_ms)) begin
                                n_cur = RS_DRY;
                            end
                        end else if (r_cur == RS_UNKNOWN) begin
                            if ((r_count >= TWO_C) && r_age_eq) begin
                                n_cur = RS_DRY;
                            end
                        end
                    end
                    n_out_valid = 1'b1;
                    n_o_state   = n_cur;
                    n_o_ready   = n_ready;
                    n_o_delta   = n_win_inc;
                    n_o_total   = n_last_total;
                    n_st        = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_cur        <= RS_UNKNOWN;
            r_ready      <= 1'b0;
            r_last_total <= '0;
            r_win_inc    <= '0;
            r_last_rain  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_st         <= n_st;
            r_head       <= n_head;
            r_count      <= n_count;
            r_cur        <= n_cur;
            r_ready      <= n_ready;
            r_last_total <= n_last_total;
            r_win_inc    <= n_win_inc;
            r_last_rain  <= n_last_rain;
            r_out_valid  <= n_out_valid;
        end
        r_now     <= n_now;
        r_ok      <= n_ok;
        r_tot     <= n_tot;
        r_age_eq  <= n_age_eq;
        r_old_tot <= n_old_tot;
        r_o_state <= n_o_state;
        r_o_ready <= n_o_ready;
        r_o_delta <= n_o_delta;
        r_o_total <= n_o_total;
    end

    assign o_in_stall     = (r_st != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_rain_state   = r_o_state;
    assign o_is_raining   = (r_o_state != RS_DRY);
    assign o_ready_res    = r_o_ready;
    assign o_window_delta = r_o_delta;
    assign o_latest_total = r_o_total;

endmodule

`default_nettype wire

// ===== design/rain_window_state_detector_top.sv =====
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------------------------
// input    | in        | i_in_valid / o_in_stall | now_ms, read_ok, total_hundredths_mm
// output   | out       | o_out_valid / i_out_stall | rain_state, is_raining, ready_res,
//          |           |                         | window_delta, latest_total
// config   | in        | i_cfg_we                | i_cfg_idx, i_cfg_wdata
//
// A good read steps through the append, read, check and update states; the check state
// pops stale samples one at a time through the single sample memory read port.
// A failed read goes from idle straight to the update state.
// Synchronous active-low reset clears the sample count; memory contents need no clear.
// A result waits in the output register while the next beat is taken; the block
// stalls its input only while a beat is in progress or its result cannot be stored.
module rain_window_state_detector_top
    import rwsd_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = 64
)(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [TS_W-1:0]      i_now_ms,
    input  wire logic                 i_read_ok,
    input  wire logic [TOT_W-1:0]     i_total_hundredths_mm,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_rain_state,
    output logic                      o_is_raining,
    output logic                      o_ready_res,
    output logic [TOT_W-1:0]          o_window_delta,
    output logic [TOT_W-1:0]          o_latest_total,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

    t_cfg          cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_sample       mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_sample       mem_rdata;

    rwsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rwsd_ring #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rwsd_ctrl #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (cfg),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_now_ms              (i_now_ms),
        .i_read_ok             (i_read_ok),
        .i_total_hundredths_mm (i_total_hundredths_mm),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_rain_state          (o_rain_state),
        .o_is_raining          (o_is_raining),
        .o_ready_res           (o_ready_res),
        .o_window_delta        (o_window_delta),
        .o_latest_total        (o_latest_total),
        .o_mem_we              (mem_we),
        .o_mem_waddr           (mem_waddr),
        .o_mem_wdata           (mem_wdata),
        .o_mem_raddr           (mem_raddr),
        .i_mem_rdata           (mem_rdata)
    );

endmodule

`default_nettype wire
